// ===== rtl/core/fvm_pkg.sv =====
// Package for the FAT volume mount parser: outcome codes, command and status structs.
// No dependencies.
`timescale 1ns / 1ps
package fvm_pkg;
	localparam int SECTOR_BYTES = 512;
	localparam int MBR_ENTRIES = 4;
	localparam int POS_W = $clog2(SECTOR_BYTES);
	localparam int PIDX_W = $clog2(MBR_ENTRIES);

	typedef enum logic [2:0] {
		OUT_MOUNTED = 3'd0,
		OUT_READ_REQ = 3'd1,
		OUT_IO_ERROR = 3'd2,
		OUT_NO_FS = 3'd3,
		OUT_BAD_PARAM = 3'd4,
		OUT_FAT12 = 3'd5
	} outcome_t;

	typedef struct packed {
		logic       byte_en;    // capture data byte
		logic       restart;    // io error: clear position and phase
		logic       calc_start; // start geometry check
		logic       div_start;  // start cluster division
		logic       finish;     // compute final fields
		logic       route;      // decide request / no fs at sector end
	} dp_cmd_t;

	typedef struct packed {
		logic       last_byte;
		logic       boot_ok;    // signature and boot sector checks pass
		logic       precheck_bad;
		logic       div_done;
	} dp_status_t;
endpackage

// ===== rtl/core/fvm_divider.sv =====
// Restoring 32/8 divider, one quotient bit per cycle.
// Depends on fvm_pkg.
`timescale 1ns / 1ps
module fvm_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import fvm_pkg::*;
	logic [31:0] q_q;
	logic [8:0]  rem_q;
	logic [7:0]  dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [8:0]  trial;
	logic [9:0]  diff;

	assign trial = {rem_q[7:0], q_q[31]};
	assign diff = {1'b0, trial} - {2'b00, dvs_q};
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[9]) begin
				rem_q <= diff[8:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/core/fvm_datapath.sv =====
// Datapath: byte capture, MBR table, geometry arithmetic and result register.
// Depends on fvm_pkg and fvm_divider.
`timescale 1ns / 1ps
module fvm_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  fvm_pkg::dp_cmd_t    cmd,
	input  logic [7:0]          data_byte,
	output fvm_pkg::dp_status_t status,
	output logic [2:0]          res_outcome,
	output logic [31:0]         res_request_lba,
	output logic                res_is_fat32,
	output logic [7:0]          res_cluster_sectors,
	output logic [15:0]         res_root_entry_count,
	output logic [31:0]         res_cluster_count,
	output logic [31:0]         res_table_lba,
	output logic [31:0]         res_root_dir_lba,
	output logic [31:0]         res_data_area_lba,
	output logic [31:0]         res_root_start_cluster
);
	import fvm_pkg::*;
	logic [POS_W-1:0]  pos_q;
	logic              phase_q;
	logic [31:0]       base_q;
	logic [31:0]       part_q [MBR_ENTRIES];
	logic [MBR_ENTRIES-1:0] valid_q;
	logic [PIDX_W-1:0] cur_q;
	logic [31:0]       size_q;
	logic [7:0]  jump_q, spc_q, fats_n_q;
	logic [15:0] bps_q, rsv_q, rent_q, tot16_q, fsz16_q, sig_q;
	logic [31:0] tot32_q, fsz32_q, rclus_q;
	logic [31:0] total_q, first_q, rsecs_q, mbase_q, prod_q, fats_q;
	logic [1:0]  calc_step_q;
	logic        div_done;
	logic [31:0] quot;
	logic [8:0]  off;
	logic [PIDX_W-1:0] pidx;
	logic [3:0]  eoff;
	logic        in_table;
	logic [31:0] base_cur;
	logic              next_found;
	logic [PIDX_W-1:0] next_idx;

	assign off = pos_q - 9'd446;
	assign pidx = off[4+PIDX_W-1:4];
	assign eoff = off[3:0];
	assign in_table = !phase_q && pos_q >= 9'd446 && pos_q < 9'd510;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= 1'b0;
			base_q <= '0;
			valid_q <= '0;
			cur_q <= '0;
			size_q <= '0;
			{jump_q, spc_q, fats_n_q} <= '0;
			{bps_q, rsv_q, rent_q, tot16_q, fsz16_q, sig_q} <= '0;
			{tot32_q, fsz32_q, rclus_q} <= '0;
		end else if (cmd.restart) begin
			pos_q <= '0;
			phase_q <= 1'b0;
			base_q <= '0;
		end else begin
			if (cmd.byte_en) begin
				pos_q <= pos_q + 9'd1;
				case (pos_q)
					9'd0: jump_q <= data_byte;
					9'd11: bps_q[7:0] <= data_byte;
					9'd12: bps_q[15:8] <= data_byte;
					9'd13: spc_q <= data_byte;
					9'd14: rsv_q[7:0] <= data_byte;
					9'd15: rsv_q[15:8] <= data_byte;
					9'd16: fats_n_q <= data_byte;
					9'd17: rent_q[7:0] <= data_byte;
					9'd18: rent_q[15:8] <= data_byte;
					9'd19: tot16_q[7:0] <= data_byte;
					9'd20: tot16_q[15:8] <= data_byte;
					9'd22: fsz16_q[7:0] <= data_byte;
					9'd23: fsz16_q[15:8] <= data_byte;
					9'd32: tot32_q[7:0] <= data_byte;
					9'd33: tot32_q[15:8] <= data_byte;
					9'd34: tot32_q[23:16] <= data_byte;
					9'd35: tot32_q[31:24] <= data_byte;
					9'd36: fsz32_q[7:0] <= data_byte;
					9'd37: fsz32_q[15:8] <= data_byte;
					9'd38: fsz32_q[23:16] <= data_byte;
					9'd39: fsz32_q[31:24] <= data_byte;
					9'd44: rclus_q[7:0] <= data_byte;
					9'd45: rclus_q[15:8] <= data_byte;
					9'd46: rclus_q[23:16] <= data_byte;
					9'd47: rclus_q[31:24] <= data_byte;
					9'd510: sig_q[7:0] <= data_byte;
					9'd511: sig_q[15:8] <= data_byte;
					default: ;
				endcase
				if (in_table && eoff >= 4'd12) begin
					size_q[8*eoff[1:0] +: 8] <= data_byte;
					if (eoff == 4'd15)
						valid_q[pidx] <= ({data_byte, size_q[23:0]} != '0)
							&& (part_q[pidx] != '0);
				end
			end
			if (cmd.calc_start)
				phase_q <= 1'b0;
			if (cmd.calc_start)
				base_q <= '0;
			if (cmd.route) begin
				if (next_found) begin
					phase_q <= 1'b1;
					cur_q <= next_idx;
					base_q <= part_q[next_idx];
				end else begin
					phase_q <= 1'b0;
					base_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_en && in_table && eoff >= 4'd8 && eoff < 4'd12)
			part_q[pidx][8*eoff[1:0] +: 8] <= data_byte;
	end

	// next valid entry after the current one (or from zero on sector zero)
	always_comb begin
		next_found = 1'b0;
		next_idx = '0;
		for (int i = MBR_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && (!phase_q || i > int'(cur_q))) begin
				next_found = 1'b1;
				next_idx = PIDX_W'(i);
			end
		end
		// sector zero without signature holds no usable table
		if (!phase_q && sig_q != 16'hAA55)
			next_found = 1'b0;
	end

	assign status.last_byte = pos_q == 9'(SECTOR_BYTES - 1);
	assign status.boot_ok = sig_q == 16'hAA55 && (jump_q == 8'hEB || jump_q == 8'hE9)
		&& bps_q == 16'(SECTOR_BYTES) && spc_q != 8'd0;
	assign base_cur = phase_q ? base_q : 32'd0;

	// geometry: step 0 selects and multiplies, step 1 sums
	logic [31:0] tot_sel, fat_sel;
	assign tot_sel = tot16_q != '0 ? {16'd0, tot16_q} : tot32_q;
	assign fat_sel = fsz16_q != '0 ? {16'd0, fsz16_q} : fsz32_q;
	always_ff @(posedge clk) begin
		if (cmd.calc_start) begin
			total_q <= tot_sel;
			fats_q <= fat_sel;
			prod_q <= 32'(fat_sel * {24'd0, fats_n_q});
			rsecs_q <= {19'd0, {1'b0, rent_q[15:4]} + {12'd0, rent_q[3:0] != 4'd0}};
			mbase_q <= base_cur;
		end
		if (calc_step_q == 2'd1)
			first_q <= {16'd0, rsv_q} + prod_q + rsecs_q;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			calc_step_q <= '0;
		else if (cmd.calc_start)
			calc_step_q <= 2'd1;
		else if (calc_step_q == 2'd1)
			calc_step_q <= 2'd2;
		else
			calc_step_q <= '0;
	end
	assign status.precheck_bad = bps_q != 16'(SECTOR_BYTES) || fats_n_q == '0
		|| rsv_q == '0 || fats_q == '0 || total_q == '0 || first_q >= total_q;

	fvm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(total_q - first_q), .divisor(spc_q),
		.done(div_done), .quotient(quot)
	);
	assign status.div_done = div_done;

	logic is32;
	assign is32 = quot >= 32'd65525;
	always_ff @(posedge clk) begin
		if (cmd.restart) begin
			res_outcome <= OUT_IO_ERROR;
			res_request_lba <= '0;
			{res_is_fat32, res_cluster_sectors, res_root_entry_count} <= '0;
			{res_cluster_count, res_table_lba, res_root_dir_lba} <= '0;
			{res_data_area_lba, res_root_start_cluster} <= '0;
		end else if (cmd.route) begin
			res_outcome <= next_found ? OUT_READ_REQ : OUT_NO_FS;
			res_request_lba <= next_found ? part_q[next_idx] : 32'd0;
			{res_is_fat32, res_cluster_sectors, res_root_entry_count} <= '0;
			{res_cluster_count, res_table_lba, res_root_dir_lba} <= '0;
			{res_data_area_lba, res_root_start_cluster} <= '0;
		end else if (cmd.div_start && status.precheck_bad) begin
			res_outcome <= OUT_BAD_PARAM;
			res_request_lba <= '0;
			{res_is_fat32, res_cluster_sectors, res_root_entry_count} <= '0;
			{res_cluster_count, res_table_lba, res_root_dir_lba} <= '0;
			{res_data_area_lba, res_root_start_cluster} <= '0;
		end else if (cmd.finish) begin
			res_request_lba <= '0;
			if (quot < 32'd4085 || (is32 && rclus_q < 32'd2)) begin
				res_outcome <= quot < 32'd4085 ? OUT_FAT12 : OUT_BAD_PARAM;
				{res_is_fat32, res_cluster_sectors, res_root_entry_count} <= '0;
				{res_cluster_count, res_table_lba, res_root_dir_lba} <= '0;
				{res_data_area_lba, res_root_start_cluster} <= '0;
			end else begin
				res_outcome <= OUT_MOUNTED;
				res_is_fat32 <= is32;
				res_cluster_sectors <= spc_q;
				res_root_entry_count <= rent_q;
				res_cluster_count <= quot;
				res_table_lba <= mbase_q + {16'd0, rsv_q};
				res_root_dir_lba <= mbase_q + first_q - rsecs_q;
				res_data_area_lba <= mbase_q + first_q;
				res_root_start_cluster <= is32 ? rclus_q : 32'd0;
			end
		end
	end
endmodule

// ===== rtl/core/fvm_ctrl.sv =====
// Controller: sector end sequencing, geometry steps and output handshake.
// Depends on fvm_pkg.
`timescale 1ns / 1ps
module fvm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_cmd,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  fvm_pkg::dp_status_t status,
	output fvm_pkg::dp_cmd_t    cmd
);
	import fvm_pkg::*;
	typedef enum logic [5:0] {
		ST_RUN   = 6'b000001,
		ST_CALC1 = 6'b000010,
		ST_CALC2 = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_FIN   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;
	state_t state_q, state_d;
	logic acc;

	assign in_ready = state_q == ST_RUN;
	assign out_valid = state_q == ST_OUT;
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_RUN: if (acc) begin
				if (in_cmd) begin
					cmd.restart = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.byte_en = 1'b1;
					if (status.last_byte)
						state_d = ST_CALC1;
				end
			end
			ST_CALC1: begin
				if (status.boot_ok) begin
					cmd.calc_start = 1'b1;
					state_d = ST_CALC2;
				end else begin
					cmd.route = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_CALC2: state_d = ST_DIV;
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d = status.precheck_bad ? ST_OUT : ST_FIN;
			end
			ST_FIN: if (status.div_done) begin
				cmd.finish = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: if (out_ready) state_d = ST_RUN;
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_RUN;
		else state_q <= state_d;
	end
endmodule

// ===== rtl/core/fat_volume_mount_parser_unit.sv =====
// FAT16/FAT32 mount parser top level: controller plus datapath.
// Depends on fvm_pkg, fvm_ctrl, fvm_datapath.
// Throughput: one data byte per cycle within a sector.
// At a sector end, a request / no-fs word follows CALC1, a mount result follows
// CALC1, CALC2, DIV, FIN (bit-serial division); input stalls until the word is taken.
// Reset: asynchronous active low; expects sector zero, no result pending.
`timescale 1ns / 1ps
module fat_volume_mount_parser_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // data_byte
	input  logic         s_tuser,  // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [223:0] m_tdata   // outcome, request_lba, is_fat32, cluster_sectors,
	                               // root_entry_count, cluster_count, table_lba,
	                               // root_dir_lba, data_area_lba, root_start_cluster, pad
);
	import fvm_pkg::*;
	dp_cmd_t cmd;
	dp_status_t status;
	logic [2:0] outcome;
	logic [31:0] req, cc, tl, rl, dl, rsc;
	logic f32;
	logic [7:0] spc;
	logic [15:0] rec;

	fvm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_cmd(s_tuser),
		.in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
		.status(status), .cmd(cmd)
	);
	fvm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(s_tdata), .status(status),
		.res_outcome(outcome), .res_request_lba(req), .res_is_fat32(f32),
		.res_cluster_sectors(spc), .res_root_entry_count(rec), .res_cluster_count(cc),
		.res_table_lba(tl), .res_root_dir_lba(rl), .res_data_area_lba(dl),
		.res_root_start_cluster(rsc)
	);
	assign m_tdata = {4'd0, rsc, dl, rl, tl, cc, rec, spc, f32, req, outcome};
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for fat_volume_mount_parser_unit: streams whole sectors,
// MBR chains and read failures, and predicts each result word in-line.
// Depends on fvm_pkg and the RTL of fat_volume_mount_parser_unit.
`timescale 1ns / 1ps
module tb;
	import fvm_pkg::*;

	typedef struct packed {
		logic [3:0]  pad;
		logic [31:0] root_start_cluster;
		logic [31:0] data_area_lba;
		logic [31:0] root_dir_lba;
		logic [31:0] table_lba;
		logic [31:0] cluster_count;
		logic [15:0] root_entry_count;
		logic [7:0]  cluster_sectors;
		logic        is_fat32;
		logic [31:0] request_lba;
		outcome_t    outcome;
	} mount_word_t;

	localparam int IDLE_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [223:0] m_tdata;

	fat_volume_mount_parser_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [8:0]  byte_pos;
	logic        phase;
	logic [31:0] sector_base;
	logic [31:0] part_start [MBR_ENTRIES];
	logic [3:0]  part_valid;
	int          cur_part;
	logic [31:0] size_acc;
	logic [7:0]  jump_byte, spc_byte, fat_copies;
	logic [15:0] bytes_per_sector, reserved_count, root_entries_raw;
	logic [15:0] total_small, fat_size_small, signature;
	logic [31:0] total_large, fat_size_large, root_cluster_raw;

	mount_word_t mount_results_q[$];
	logic [7:0]  sec[SECTOR_BYTES];
	int          errors = 0;
	int          burst_left = 0;
	int          idle_cycles = 0;
	int          hold_left = 0;
	bit          long_hold_req = 0;
	int          stall_mode = 0;
	int          stall_left = 0;

	function automatic mount_word_t mount_result(input logic [31:0] base);
		mount_word_t w;
		logic [31:0] total, fats, root_secs, first, clusters;
		logic fat32;
		w = '0;
		w.outcome = OUT_BAD_PARAM;
		if (bytes_per_sector != SECTOR_BYTES) return w;
		total = (total_small != 0) ? 32'(total_small) : total_large;
		fats = (fat_size_small != 0) ? 32'(fat_size_small) : fat_size_large;
		if (spc_byte == 0 || fat_copies == 0 || reserved_count == 0 || fats == 0 || total == 0)
			return w;
		root_secs = (32'(root_entries_raw) * 32'd32 + 32'd511) / 32'd512;
		first = 32'(reserved_count) + 32'(fat_copies) * fats + root_secs;
		if (first >= total) return w;
		clusters = (total - first) / 32'(spc_byte);
		if (clusters < 32'd4085) begin
			w.outcome = OUT_FAT12;
			return w;
		end
		fat32 = clusters >= 32'd65525;
		if (fat32 && root_cluster_raw < 2) return w;
		w.outcome = OUT_MOUNTED;
		w.is_fat32 = fat32;
		w.cluster_sectors = spc_byte;
		w.root_entry_count = root_entries_raw;
		w.cluster_count = clusters;
		w.table_lba = base + 32'(reserved_count);
		w.root_dir_lba = base + first - root_secs;
		w.data_area_lba = base + first;
		w.root_start_cluster = fat32 ? root_cluster_raw : 32'd0;
		return w;
	endfunction

	task automatic predict_word(input logic cmd, input logic [7:0] b);
		mount_word_t w;
		int pos, off, p, e, nxt;
		logic [31:0] base;
		w = '0;
		pos = byte_pos;
		if (cmd) begin
			byte_pos = 0; phase = 0; sector_base = 0;
			w.outcome = OUT_IO_ERROR;
			mount_results_q.push_back(w);
			return;
		end
		if (pos == 0) jump_byte = b;
		else if (pos inside {11, 12}) bytes_per_sector[8*(pos-11) +: 8] = b;
		else if (pos == 13) spc_byte = b;
		else if (pos inside {14, 15}) reserved_count[8*(pos-14) +: 8] = b;
		else if (pos == 16) fat_copies = b;
		else if (pos inside {17, 18}) root_entries_raw[8*(pos-17) +: 8] = b;
		else if (pos inside {19, 20}) total_small[8*(pos-19) +: 8] = b;
		else if (pos inside {22, 23}) fat_size_small[8*(pos-22) +: 8] = b;
		else if (pos >= 32 && pos < 36) total_large[8*(pos-32) +: 8] = b;
		else if (pos >= 36 && pos < 40) fat_size_large[8*(pos-36) +: 8] = b;
		else if (pos >= 44 && pos < 48) root_cluster_raw[8*(pos-44) +: 8] = b;
		else if (pos >= 510) signature[8*(pos-510) +: 8] = b;
		if (phase == 0 && pos >= 446 && pos < 510) begin
			off = pos - 446; p = off / 16; e = off % 16;
			if (e >= 8 && e < 12) part_start[p][8*(e-8) +: 8] = b;
			else if (e >= 12) begin
				size_acc[8*(e-12) +: 8] = b;
				if (e == 15) part_valid[p] = (size_acc != 0 && part_start[p] != 0);
			end
		end
		if (pos != SECTOR_BYTES - 1) begin
			byte_pos = 9'(pos + 1);
			return;
		end
		byte_pos = 0;
		if (signature == 16'hAA55 && (jump_byte == 8'hEB || jump_byte == 8'hE9)
				&& bytes_per_sector == SECTOR_BYTES && spc_byte != 0) begin
			base = phase ? sector_base : 32'd0;
			phase = 0; sector_base = 0;
			mount_results_q.push_back(mount_result(base));
			return;
		end
		if (phase == 0 && signature != 16'hAA55) begin
			w.outcome = OUT_NO_FS;
			mount_results_q.push_back(w);
			return;
		end
		nxt = (phase == 0) ? 0 : cur_part + 1;
		while (nxt < MBR_ENTRIES && !part_valid[nxt]) nxt++;
		if (nxt >= MBR_ENTRIES) begin
			phase = 0; sector_base = 0;
			w.outcome = OUT_NO_FS;
		end else begin
			phase = 1; cur_part = nxt; sector_base = part_start[nxt];
			w.outcome = OUT_READ_REQ;
			w.request_lba = sector_base;
		end
		mount_results_q.push_back(w);
	endtask

	task automatic send_word(input logic cmd, input logic [7:0] b);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 2000 : $urandom_range(1, 80);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		predict_word(cmd, b);
	endtask

	// abort_at < 0 sends the full sector; otherwise a read failure replaces that byte
	task automatic send_sector(input int abort_at);
		for (int i = 0; i < SECTOR_BYTES; i++) begin
			if (i == abort_at) begin
				send_word(1'b1, 8'($urandom_range(0, 255)));
				return;
			end
			send_word(1'b0, sec[i]);
		end
	endtask

	task automatic make_boot(input logic [7:0] jmp, input logic [15:0] bps, input logic [7:0] spc,
			input logic [15:0] res, input logic [7:0] copies, input logic [15:0] rootent,
			input logic [15:0] tot16, input logic [15:0] fsz16, input logic [31:0] tot32,
			input logic [31:0] fsz32, input logic [31:0] rclus);
		for (int i = 0; i < SECTOR_BYTES; i++) sec[i] = 8'($urandom_range(0, 255));
		sec[0] = jmp;
		{sec[12], sec[11]} = bps;
		sec[13] = spc;
		{sec[15], sec[14]} = res;
		sec[16] = copies;
		{sec[18], sec[17]} = rootent;
		{sec[20], sec[19]} = tot16;
		{sec[23], sec[22]} = fsz16;
		{sec[35], sec[34], sec[33], sec[32]} = tot32;
		{sec[39], sec[38], sec[37], sec[36]} = fsz32;
		{sec[47], sec[46], sec[45], sec[44]} = rclus;
		sec[510] = 8'h55;
		sec[511] = 8'hAA;
	endtask

	task automatic make_mbr(input logic [31:0] st [MBR_ENTRIES], input logic [31:0] sz [MBR_ENTRIES]);
		for (int i = 0; i < SECTOR_BYTES; i++) sec[i] = 8'($urandom_range(0, 255));
		sec[0] = 8'h00;
		for (int p = 0; p < MBR_ENTRIES; p++)
			for (int k = 0; k < 4; k++) begin
				sec[446 + 16*p + 8 + k] = st[p][8*k +: 8];
				sec[446 + 16*p + 12 + k] = sz[p][8*k +: 8];
			end
		sec[510] = 8'h55;
		sec[511] = 8'hAA;
	endtask

	task automatic random_boot();
		logic [7:0] spc, copies, jmp;
		logic [15:0] res, rootent, bps;
		logic [31:0] fsz, cls, tot, rclus;
		bit fat32;
		fat32 = 1'($urandom_range(0, 1));
		spc = 8'(1 << $urandom_range(0, 7));
		if ($urandom_range(0, 9) == 0) spc = 8'($urandom_range(0, 255));
		res = fat32 ? 16'd32 : 16'd1;
		if ($urandom_range(0, 7) == 0) res = 16'($urandom_range(0, 65535));
		copies = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'd2;
		rootent = fat32 ? 16'd0 : 16'd512;
		if ($urandom_range(0, 7) == 0) rootent = 16'($urandom_range(0, 65535));
		fsz = $urandom_range(1, 600);
		case ($urandom_range(0, 2))
			0: cls = $urandom_range(1, 4084);
			1: cls = $urandom_range(4085, 65524);
			default: cls = $urandom_range(65525, 4000000);
		endcase
		tot = 32'(res) + 32'(copies) * fsz + (32'(rootent) * 32 + 511) / 512 + cls * 32'(spc);
		if ($urandom_range(0, 9) == 0) tot = $urandom;
		rclus = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 1)) : $urandom;
		jmp = $urandom_range(0, 1) ? 8'hEB : 8'hE9;
		if ($urandom_range(0, 15) == 0) jmp = 8'($urandom_range(0, 255));
		bps = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 65535)) : 16'd512;
		if (tot < 65536 && $urandom_range(0, 1))
			make_boot(jmp, bps, spc, res, copies, rootent, 16'(tot), 16'(fsz), $urandom, $urandom, rclus);
		else
			make_boot(jmp, bps, spc, res, copies, rootent, 16'd0,
				fat32 ? 16'd0 : 16'(fsz), tot, fat32 ? fsz : $urandom, rclus);
		if ($urandom_range(0, 15) == 0) sec[511] = 8'($urandom_range(0, 255));
	endtask

	task automatic random_mbr();
		logic [31:0] st [MBR_ENTRIES];
		logic [31:0] sz [MBR_ENTRIES];
		for (int p = 0; p < MBR_ENTRIES; p++) begin
			st[p] = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
			sz[p] = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
		end
		make_mbr(st, sz);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (mount_results_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_boundaries();
		logic [31:0] st [MBR_ENTRIES];
		logic [31:0] sz [MBR_ENTRIES];
		send_word(1'b1, 8'hFF);
		make_boot(8'hEB, 512, 1, 1, 1, 0, 16'd4086, 1, 0, 0, 0); send_sector(-1);
		make_boot(8'hE9, 512, 1, 1, 1, 0, 16'd4087, 1, 0, 0, 0); send_sector(-1);
		make_boot(8'hEB, 512, 1, 1, 1, 0, 0, 1, 32'd65526, 0, 0); send_sector(-1);
		make_boot(8'hEB, 512, 1, 1, 1, 0, 0, 1, 32'd65527, 0, 2); send_sector(-1);
		make_boot(8'hEB, 512, 1, 1, 1, 0, 0, 1, 32'd65527, 0, 1); send_sector(-1);
		make_boot(8'hEB, 512, 255, 16'hFFFF, 255, 16'hFFFF, 0, 0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF); send_sector(-1);
		make_boot(8'hEB, 512, 8, 32, 0, 0, 0, 0, 32'd1000000, 100, 2); send_sector(-1);
		make_boot(8'hEB, 512, 1, 100, 2, 512, 16'd100, 4, 0, 0, 0); send_sector(-1);
		make_boot(8'hEB, 16'd1024, 1, 1, 1, 0, 0, 1, 32'd70000, 0, 2); send_sector(-1);
		for (int i = 0; i < SECTOR_BYTES; i++) sec[i] = 8'h00;
		send_sector(-1);
		for (int i = 0; i < SECTOR_BYTES; i++) sec[i] = 8'hFF;
		send_sector(-1);
		st = '{0, 0, 0, 0}; sz = '{5, 0, 0, 0};
		make_mbr(st, sz); send_sector(-1);
		st = '{32'hFFFF_FFFF, 0, 8, 63}; sz = '{1, 9, 32'hFFFF_FFFF, 4};
		make_mbr(st, sz); send_sector(-1);
		for (int i = 0; i < SECTOR_BYTES; i++) sec[i] = 8'($urandom_range(0, 255));
		sec[0] = 8'h00; send_sector(-1);
		sec[510] = 8'h00; send_sector(-1);
		make_boot(8'hEB, 512, 4, 32, 2, 0, 0, 0, 32'd2000000, 1000, 2); send_sector(-1);
		make_mbr(st, sz); send_sector(-1);
		send_sector(100);
		make_mbr(st, sz); send_sector(300);
		wait_drained();
	endtask

	task automatic test_random_volumes(input int n);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin random_boot(); send_sector(-1); end
				3, 4, 5, 6: begin
					random_mbr();
					send_sector(-1);
					while (phase == 1) begin
						case ($urandom_range(0, 9))
							0, 1: begin
								for (int i = 0; i < SECTOR_BYTES; i++)
									sec[i] = 8'($urandom_range(0, 255));
								send_sector(-1);
							end
							2: send_sector($urandom_range(0, 511));
							default: begin random_boot(); send_sector(-1); end
						endcase
					end
				end
				7, 8: begin
					for (int i = 0; i < SECTOR_BYTES; i++) sec[i] = 8'($urandom_range(0, 255));
					if ($urandom_range(0, 1)) begin sec[510] = 8'h55; sec[511] = 8'hAA; end
					send_sector(-1);
				end
				default: begin random_boot(); send_sector($urandom_range(0, 511)); end
			endcase
		end
	endtask

	task automatic test_backpressure();
		long_hold_req = 1;
		random_mbr();
		send_sector(-1);
		random_boot();
		send_sector(-1);
		wait_drained();
		random_boot();
		send_sector(-1);
		wait_drained();
	endtask

	// result checker and receiver stall pattern
	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		mount_word_t got, want;
		if (m_tvalid && m_tready) begin
			got = mount_word_t'(m_tdata);
			if (mount_results_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word expected none actual %h", $time, m_tdata);
			end else begin
				want = mount_results_q.pop_front();
				check_field("outcome", 32'(want.outcome), 32'(got.outcome));
				check_field("request_lba", want.request_lba, got.request_lba);
				check_field("is_fat32", 32'(want.is_fat32), 32'(got.is_fat32));
				check_field("cluster_sectors", 32'(want.cluster_sectors), 32'(got.cluster_sectors));
				check_field("root_entry_count", 32'(want.root_entry_count), 32'(got.root_entry_count));
				check_field("cluster_count", want.cluster_count, got.cluster_count);
				check_field("table_lba", want.table_lba, got.table_lba);
				check_field("root_dir_lba", want.root_dir_lba, got.root_dir_lba);
				check_field("data_area_lba", want.data_area_lba, got.data_area_lba);
				check_field("root_start_cluster", want.root_start_cluster, got.root_start_cluster);
			end
		end
		if (long_hold_req) begin
			long_hold_req = 0;
			hold_left = 1500;
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(10, 300);
		end else
			stall_left--;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("fat_volume_mount_parser_unit verification failed");
			$finish;
		end
	end

	initial begin
		byte_pos = 0; phase = 0; sector_base = 0; part_valid = '0; cur_part = 0; size_acc = 0;
		for (int p = 0; p < MBR_ENTRIES; p++) part_start[p] = '0;
		jump_byte = 0; spc_byte = 0; fat_copies = 0; bytes_per_sector = 0; reserved_count = 0;
		root_entries_raw = 0; total_small = 0; fat_size_small = 0; signature = 0;
		total_large = 0; fat_size_large = 0; root_cluster_raw = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_boundaries();
		test_backpressure();
		test_random_volumes(70);
		wait_drained();
		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("fat_volume_mount_parser_unit verification clean");
		else
			$display("fat_volume_mount_parser_unit verification failed");
		$finish;
	end
endmodule
